// ===== sv/point_cloud_max_height_grid_assert.svh =====
// assertion macros for the max-height grid
// used by point_cloud_max_height_grid.sv, which provides clk and rst_n
`ifndef POINT_CLOUD_MAX_HEIGHT_GRID_ASSERT_SVH
`define POINT_CLOUD_MAX_HEIGHT_GRID_ASSERT_SVH

// same-cycle implication
`define PCG_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("grid assertion failed");

// next-cycle implication
`define PCG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("grid assertion failed");

`endif

// ===== sv/pcg_pkg.sv =====
// types and constants of the max-height grid
// no dependencies
`default_nettype none

package pcg_pkg;

  localparam int MAX_COLS   = 128;
  localparam int MAX_ROWS   = 128;
  localparam int COL_W      = 7;
  localparam int ROW_W      = 7;
  localparam int CELL_AW    = ROW_W + COL_W;
  localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;
  localparam int HGT_W      = 15;
  localparam int WORD_W     = HGT_W + 1;

  localparam logic signed [7:0] EMPTY_VALUE = -8'sd1;

  localparam logic [1:0] CFG_CELLS_PER_METRE = 2'd0;
  localparam logic [1:0] CFG_GRID_WIDTH      = 2'd1;
  localparam logic [1:0] CFG_GRID_HEIGHT     = 2'd2;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CALC,
    S_LOOK,
    S_RMW
  } state_t;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [23:0] coord_x;
    logic signed [23:0] coord_y;
    logic signed [15:0] coord_z;
    logic [6:0]         cell_col;
    logic [6:0]         cell_row;
  } in_beat_t;

  typedef struct packed {
    logic signed [7:0] cell_value;
    logic              point_in_grid;
  } out_beat_t;

endpackage

`default_nettype wire

// ===== sv/point_cloud_max_height_grid.sv =====
// an accepted beat passes through S_CALC (index multiply), S_LOOK (cell memory read)
// and S_RMW (write-back), which waits while the output is stalled; no new beat is
// taken before S_IDLE; reset (synchronous, rst_n low) and every start command
// clear the whole cell memory, in_ready low meanwhile; config writes still taken
// depends on pcg_pkg and point_cloud_max_height_grid_assert.svh
`default_nettype none
`include "point_cloud_max_height_grid_assert.svh"

module point_cloud_max_height_grid
  import pcg_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_beat_t   in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_beat_t       out_data,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_wdata
);

  state_t state_r, state_nxt;

  logic [7:0] cfg_cpm_r, cfg_gw_r, cfg_gh_r;
  logic signed [23:0] origin_x_r, origin_y_r;

  in_beat_t item_r;
  logic signed [32:0] prod_x_r, prod_y_r, prod_x_nxt, prod_y_nxt;
  logic signed [24:0] diff_x, diff_y, cell_x, cell_y;
  logic signed [8:0]  cpm_s;
  logic [7:0] cols_use, rows_use;
  logic col_ok, row_ok, look_inside;
  logic [CELL_AW-1:0] look_idx;

  logic [CELL_AW-1:0] idx_r;
  logic inside_r;

  logic [WORD_W-1:0] mem [CELL_COUNT];
  logic [WORD_W-1:0] rd_data_r;
  logic mem_we, mem_re;
  logic [CELL_AW-1:0] mem_waddr;
  logic [WORD_W-1:0] mem_wdata;

  logic [CELL_AW-1:0] clr_cnt_r, clr_cnt_nxt;

  logic out_valid_r, out_valid_nxt, out_load;
  out_beat_t out_data_r, out_nxt;

  logic rd_occ;
  logic [HGT_W-1:0] rd_hgt, new_hgt, new_max;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_cpm_r <= 8'd10;
      cfg_gw_r  <= 8'd100;
      cfg_gh_r  <= 8'd100;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CELLS_PER_METRE: cfg_cpm_r <= cfg_wdata;
        CFG_GRID_WIDTH:      cfg_gw_r  <= cfg_wdata;
        CFG_GRID_HEIGHT:     cfg_gh_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // index arithmetic
  always_comb begin
    cpm_s      = signed'({1'b0, cfg_cpm_r});
    diff_x     = 25'(item_r.coord_x) - 25'(origin_x_r);
    diff_y     = 25'(item_r.coord_y) - 25'(origin_y_r);
    prod_x_nxt = 33'(diff_x) * 33'(cpm_s);
    prod_y_nxt = 33'(diff_y) * 33'(cpm_s);
  end

  always_comb begin
    // divide by 256 rounding toward zero
    cell_x   = prod_x_r[32] ? 25'((prod_x_r + 33'sd255) >>> 8) : 25'(prod_x_r >>> 8);
    cell_y   = prod_y_r[32] ? 25'((prod_y_r + 33'sd255) >>> 8) : 25'(prod_y_r >>> 8);
    cols_use = (cfg_gw_r > 8'(MAX_COLS)) ? 8'(MAX_COLS) : cfg_gw_r;
    rows_use = (cfg_gh_r > 8'(MAX_ROWS)) ? 8'(MAX_ROWS) : cfg_gh_r;
    col_ok   = !cell_x[24] && (cell_x[23:0] < 24'(cols_use));
    row_ok   = !cell_y[24] && (cell_y[23:0] < 24'(rows_use));
    if (item_r.command == CMD_READ) begin
      look_inside = ({1'b0, item_r.cell_col} < cols_use) &&
                    ({1'b0, item_r.cell_row} < rows_use);
      look_idx    = {item_r.cell_row, item_r.cell_col};
    end else begin
      look_inside = col_ok && row_ok;
      look_idx    = {cell_y[ROW_W-1:0], cell_x[COL_W-1:0]};
    end
  end

  // read-modify-write of one cell
  always_comb begin
    rd_occ  = rd_data_r[WORD_W-1];
    rd_hgt  = rd_data_r[HGT_W-1:0];
    new_hgt = item_r.coord_z[15] ? '0 : item_r.coord_z[HGT_W-1:0];
    new_max = (!rd_occ || (new_hgt > rd_hgt)) ? new_hgt : rd_hgt;
    out_nxt = '0;
    case (item_r.command)
      CMD_ADD:  out_nxt.point_in_grid = inside_r;
      CMD_READ: out_nxt.cell_value = (inside_r && rd_occ) ?
                                     signed'({1'b0, rd_hgt[HGT_W-1:8]}) : EMPTY_VALUE;
      default:  out_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_load      = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        if (clr_cnt_r == CELL_AW'(CELL_COUNT - 1)) begin
          clr_cnt_nxt = '0;
          state_nxt   = S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: state_nxt = S_LOOK;
      S_LOOK: begin
        mem_re    = 1'b1;
        state_nxt = S_RMW;
      end
      S_RMW: begin
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          if ((item_r.command == CMD_ADD) && inside_r) begin
            mem_we    = 1'b1;
            mem_waddr = idx_r;
            mem_wdata = {1'b1, new_max};
          end
          state_nxt = (item_r.command == CMD_START) ? S_CLEAR : S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
    end else if (out_load && (item_r.command == CMD_START)) begin
      origin_x_r <= item_r.coord_x;
      origin_y_r <= item_r.coord_y;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    if (state_r == S_CALC) begin
      prod_x_r <= prod_x_nxt;
      prod_y_r <= prod_y_nxt;
    end
    if (state_r == S_LOOK) begin
      idx_r    <= look_idx;
      inside_r <= look_inside;
    end
    if (out_load) begin
      out_data_r <= out_nxt;
    end
  end

  // cell memory: occupied flag over max height
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[look_idx];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `PCG_ASSERT_IMPL(a_mem_write_state, mem_we, (state_r == S_CLEAR) || (state_r == S_RMW))
  `PCG_ASSERT_NEXT(a_accept_to_calc, in_valid && in_ready, state_r == S_CALC)
  `PCG_ASSERT_NEXT(a_result_from_rmw, !out_valid_r && (state_r != S_RMW), !out_valid_r)

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// testbench for point_cloud_max_height_grid: a directed table, then random phases over
// several grid settings, every result beat checked against a known value from the table or an in-bench height map
// depends on pcg_pkg and the RTL of point_cloud_max_height_grid

module testbench;
  import pcg_pkg::*;

  localparam int ITEMS       = 1800;
  localparam int PHASES      = 7;
  localparam int CYCLE_LIMIT = 4_000_000;

  typedef struct {
    bit         is_cfg;
    logic [1:0] reg_idx;
    logic [7:0] reg_val;
    in_beat_t   beat;
    bit         typed;
    out_beat_t  result;
  } row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_beat_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_beat_t  out_data;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_wdata = '0;

  // known result travelling with the beat on the input side
  bit        beat_typed = 1'b0;
  out_beat_t beat_known = '0;

  // height map as the block should hold it
  int               scale_m;
  int               width_m;
  int               height_m;
  longint           org_x_m;
  longint           org_y_m;
  bit               occupied_m [CELL_COUNT];
  logic [HGT_W-1:0] max_hgt_m [CELL_COUNT];

  out_beat_t cell_result_q [$];
  out_beat_t predicted;
  out_beat_t oldest;
  int        fail_count = 0;
  int        cycle_count = 0;
  bit        steady = 1'b0;

  // settings and origin as the stimulus sees them
  int stim_scale;
  int stim_cols;
  int stim_rows;
  int stim_ox;
  int stim_oy;

  int phase_scale [PHASES] = '{1, 255, 10, 0, 0, 3, 128};
  int phase_cols  [PHASES] = '{1, 128, 100, 9, 0, 128, 0};
  int phase_rows  [PHASES] = '{1, 128, 100, 255, 0, 1, 64};

  row_t dir_rows [$];

  point_cloud_max_height_grid DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic longint cell_index(input logic signed [23:0] coord, input longint org);
    longint prod;
    prod = (longint'(coord) - org) * longint'(scale_m);
    return prod / 256;
  endfunction

  function automatic out_beat_t height_map_step(input in_beat_t b);
    out_beat_t        r;
    longint           col;
    longint           row;
    int               cols;
    int               rows;
    int               idx;
    logic [HGT_W-1:0] h;
    r = '0;
    cols = (width_m < MAX_COLS) ? width_m : MAX_COLS;
    rows = (height_m < MAX_ROWS) ? height_m : MAX_ROWS;
    case (cmd_t'(b.command))
      CMD_START: begin
        org_x_m = longint'(b.coord_x);
        org_y_m = longint'(b.coord_y);
        foreach (occupied_m[i]) occupied_m[i] = 1'b0;
      end
      CMD_ADD: begin
        col = cell_index(b.coord_x, org_x_m);
        row = cell_index(b.coord_y, org_y_m);
        if (col >= 0 && row >= 0 && col < cols && row < rows) begin
          idx = int'(row) * MAX_COLS + int'(col);
          h = (b.coord_z > 0) ? b.coord_z[HGT_W-1:0] : '0;
          r.point_in_grid = 1'b1;
          if (!occupied_m[idx] || h > max_hgt_m[idx]) max_hgt_m[idx] = h;
          occupied_m[idx] = 1'b1;
        end
      end
      CMD_READ: begin
        r.cell_value = EMPTY_VALUE;
        if (b.cell_col < cols && b.cell_row < rows) begin
          idx = int'(b.cell_row) * MAX_COLS + int'(b.cell_col);
          if (occupied_m[idx]) r.cell_value = {1'b0, max_hgt_m[idx][HGT_W-1:8]};
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      scale_m = 10;
      width_m = 100;
      height_m = 100;
      org_x_m = 0;
      org_y_m = 0;
      foreach (occupied_m[i]) occupied_m[i] = 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CELLS_PER_METRE: scale_m = cfg_wdata;
          CFG_GRID_WIDTH:      width_m = cfg_wdata;
          CFG_GRID_HEIGHT:     height_m = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (cell_result_q.size() == 0) begin
          $error("result beat with nothing expected: cell_value %0d point_in_grid %0d",
                 out_data.cell_value, out_data.point_in_grid);
          fail_count++;
        end else begin
          oldest = cell_result_q.pop_front();
          if (out_data.cell_value !== oldest.cell_value) begin
            $error("cell_value: expected %0d, got %0d", oldest.cell_value,
                   out_data.cell_value);
            fail_count++;
          end
          if (out_data.point_in_grid !== oldest.point_in_grid) begin
            $error("point_in_grid: expected %0d, got %0d", oldest.point_in_grid,
                   out_data.point_in_grid);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        predicted = height_map_step(in_data);
        cell_result_q.push_back(beat_typed ? beat_known : predicted);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL point_cloud_max_height_grid");
      $finish;
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic drive_beat(input in_beat_t b, input bit typed, input out_beat_t known);
    int gap;
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_data    <= b;
    beat_typed <= typed;
    beat_known <= known;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (cell_result_q.size() != 0);
  endtask

  function automatic in_beat_t make_beat(cmd_t c, int x, int y, int z, int col, int row);
    in_beat_t b;
    b.command  = c;
    b.coord_x  = 24'(x);
    b.coord_y  = 24'(y);
    b.coord_z  = 16'(z);
    b.cell_col = 7'(col);
    b.cell_row = 7'(row);
    return b;
  endfunction

  function automatic row_t op_row(cmd_t c, int x, int y, int z, int col, int row);
    row_t r;
    r.is_cfg  = 1'b0;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.beat    = make_beat(c, x, y, z, col, row);
    r.typed   = 1'b0;
    r.result  = '0;
    return r;
  endfunction

  function automatic row_t known_row(cmd_t c, int x, int y, int z, int col, int row,
                                     int val, bit in_grid);
    row_t r;
    r = op_row(c, x, y, z, col, row);
    r.typed = 1'b1;
    r.result.cell_value = 8'(val);
    r.result.point_in_grid = in_grid;
    return r;
  endfunction

  function automatic row_t reg_row(logic [1:0] idx, int val);
    row_t r;
    r = op_row(CMD_NONE, 0, 0, 0, 0, 0);
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = 8'(val);
    return r;
  endfunction

  // offset from the origin that lands in, or just outside, a cell of the grid
  function automatic int cell_offset(int span);
    int target;
    if (stim_scale == 0) return int'($urandom_range(0, 2000)) - 1000;
    if ($urandom_range(0, 9) == 0) return -int'($urandom_range(0, 256 / stim_scale + 1));
    if ($urandom_range(0, 1) == 0)
      target = $urandom_range(0, (span < 4) ? span - 1 : 3);
    else
      target = $urandom_range(0, span - 1);
    if ($urandom_range(0, 19) == 0) target = span;
    return (target * 256 + int'($urandom_range(0, 255))) / stim_scale;
  endfunction

  function automatic in_beat_t random_beat();
    in_beat_t    b;
    logic [95:0] raw;
    int          pick;
    int          cols;
    int          rows;
    int          z;
    int          col;
    int          row;
    pick = $urandom_range(0, 199);
    raw = {$urandom, $urandom, $urandom};
    cols = (stim_cols < 1) ? 1 : ((stim_cols > MAX_COLS) ? MAX_COLS : stim_cols);
    rows = (stim_rows < 1) ? 1 : ((stim_rows > MAX_ROWS) ? MAX_ROWS : stim_rows);
    case ($urandom_range(0, 11))
      0: z = -32768;
      1: z = 32767;
      2: z = 0;
      3: z = -1;
      default: z = int'($urandom_range(0, 65535)) - 32768;
    endcase
    if (pick == 0) begin
      stim_ox = int'($urandom_range(0, 16_000_000)) - 8_000_000;
      stim_oy = int'($urandom_range(0, 16_000_000)) - 8_000_000;
      b = make_beat(CMD_START, stim_ox, stim_oy, z, $urandom_range(0, 127),
                    $urandom_range(0, 127));
    end else if (pick < 110) begin
      b = make_beat(CMD_ADD, stim_ox + cell_offset(cols), stim_oy + cell_offset(rows), z,
                    $urandom_range(0, 127), $urandom_range(0, 127));
    end else if (pick < 160) begin
      if ($urandom_range(0, 1) == 0) begin
        col = $urandom_range(0, 3);
        row = $urandom_range(0, 3);
      end else begin
        col = $urandom_range(0, (cols + 1 > 127) ? 127 : cols + 1);
        row = $urandom_range(0, (rows + 1 > 127) ? 127 : rows + 1);
      end
      b = make_beat(CMD_READ, raw[23:0], raw[47:24], z, col, row);
    end else if (pick < 185) begin
      b = raw[$bits(in_beat_t)-1:0];
      if (b.command == CMD_START) b.command = CMD_ADD;
    end else if (pick < 195) begin
      b = raw[$bits(in_beat_t)-1:0];
      b.command = CMD_READ;
    end else begin
      b = raw[$bits(in_beat_t)-1:0];
      b.command = CMD_NONE;
    end
    return b;
  endfunction

  initial begin
    int n;
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      n = steady ? 0 : idle_len();
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: 10 cells per metre, 100 by 100, origin at zero
    dir_rows.push_back(known_row(CMD_READ, 0, 0, 0, 0, 0, EMPTY_VALUE, 1'b0));
    dir_rows.push_back(known_row(CMD_READ, 0, 0, 0, 127, 127, EMPTY_VALUE, 1'b0));
    dir_rows.push_back(known_row(CMD_ADD, 0, 0, 32767, 0, 0, 0, 1'b1));
    dir_rows.push_back(known_row(CMD_READ, 0, 0, 0, 0, 0, 127, 1'b0));
    dir_rows.push_back(known_row(CMD_ADD, -25, -25, -32768, 0, 0, 0, 1'b1));
    dir_rows.push_back(known_row(CMD_ADD, -26, 0, 100, 0, 0, 0, 1'b0));
    dir_rows.push_back(known_row(CMD_ADD, 8388607, 8388607, 0, 0, 0, 0, 1'b0));
    dir_rows.push_back(known_row(CMD_ADD, 256, 256, -1, 0, 0, 0, 1'b1));
    dir_rows.push_back(known_row(CMD_READ, 0, 0, 0, 10, 10, 0, 1'b0));
    dir_rows.push_back(op_row(CMD_ADD, 281, 281, 384, 0, 0));
    dir_rows.push_back(known_row(CMD_READ, 0, 0, 0, 10, 10, 1, 1'b0));
    dir_rows.push_back(op_row(CMD_ADD, 2535, 2535, 1000, 0, 0));
    dir_rows.push_back(op_row(CMD_ADD, 2560, 0, 0, 0, 0));
    dir_rows.push_back(known_row(CMD_NONE, -1, -1, -1, 127, 127, 0, 1'b0));
    dir_rows.push_back(known_row(CMD_START, -8388608, 8388607, 0, 0, 0, 0, 1'b0));
    dir_rows.push_back(known_row(CMD_READ, 0, 0, 0, 0, 0, EMPTY_VALUE, 1'b0));
    dir_rows.push_back(known_row(CMD_ADD, -8388608, 8388607, 256, 0, 0, 0, 1'b1));
    // zero scale folds every point into the first cell
    dir_rows.push_back(reg_row(CFG_CELLS_PER_METRE, 0));
    dir_rows.push_back(known_row(CMD_ADD, 8388607, -8388608, 767, 0, 0, 0, 1'b1));
    dir_rows.push_back(known_row(CMD_READ, 0, 0, 0, 0, 0, 2, 1'b0));
    dir_rows.push_back(reg_row(CFG_GRID_WIDTH, 0));
    dir_rows.push_back(known_row(CMD_ADD, 0, 0, 5, 0, 0, 0, 1'b0));
    dir_rows.push_back(known_row(CMD_READ, 0, 0, 0, 0, 0, EMPTY_VALUE, 1'b0));
    // oversized grid clamps to the full store
    dir_rows.push_back(reg_row(CFG_CELLS_PER_METRE, 255));
    dir_rows.push_back(reg_row(CFG_GRID_WIDTH, 255));
    dir_rows.push_back(reg_row(CFG_GRID_HEIGHT, 255));
    dir_rows.push_back(known_row(CMD_READ, 0, 0, 0, 127, 127, EMPTY_VALUE, 1'b0));
    dir_rows.push_back(op_row(CMD_ADD, -8388480, 8388607, 32767, 0, 0));
    dir_rows.push_back(known_row(CMD_READ, 0, 0, 0, 127, 0, 127, 1'b0));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        drain();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        drive_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].result);
      end
    end

    phase_scale[4] = $urandom_range(1, 255);
    phase_cols[4]  = $urandom_range(1, 128);
    phase_rows[4]  = $urandom_range(1, 128);
    for (int p = 0; p < PHASES; p++) begin
      drain();
      stim_scale = phase_scale[p];
      stim_cols  = phase_cols[p];
      stim_rows  = phase_rows[p];
      write_reg(CFG_CELLS_PER_METRE, 8'(stim_scale));
      write_reg(CFG_GRID_WIDTH, 8'(stim_cols));
      write_reg(CFG_GRID_HEIGHT, 8'(stim_rows));
      stim_ox = int'($urandom_range(0, 16_000_000)) - 8_000_000;
      stim_oy = int'($urandom_range(0, 16_000_000)) - 8_000_000;
      drive_beat(make_beat(CMD_START, stim_ox, stim_oy, 0, 0, 0), 1'b0, '0);
      for (int k = 0; k < ITEMS / PHASES; k++) begin
        if (k % 64 == 0) steady = ($urandom_range(0, 3) == 0);
        drive_beat(random_beat(), 1'b0, '0);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("PASS point_cloud_max_height_grid");
    else
      $display("FAIL point_cloud_max_height_grid");
    $finish;
  end

endmodule
